### rtl/psc_pkg.sv
// Package for the path slash normalizer: field widths, scan modes and the
// result and step structs. No dependencies.
package psc_pkg;

    // Field widths of the channels
    localparam int CODE_W    = 21;
    localparam int CHAR_BITS = 21;

    // Only the low CHAR_BITS bits of a character take part
    localparam logic [CODE_W-1:0] CHAR_MASK =
        (CHAR_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << CHAR_BITS) - 64'd1);

    localparam logic [CODE_W-1:0] SLASH_CHAR = CODE_W'(8'h2F);

    // Position within the current path
    typedef enum logic [2:0] {
        MODE_START = 3'd0,  // path start
        MODE_ROOT1 = 3'd1,  // one leading slash emitted
        MODE_ROOT2 = 3'd2,  // second leading slash held
        MODE_ROOT3 = 3'd3,  // three or more leading slashes seen
        MODE_BODY  = 3'd4,  // inside the path
        MODE_RUN   = 3'd5   // slash run held
    } t_scan_mode;

    // One result beat
    typedef struct packed {
        logic [CODE_W-1:0] out_char;
        logic              has_char;
        logic              path_end;
    } t_result;

    // Results caused by one input beat, in order res0 then res1
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

endpackage

### rtl/psc_if.sv
// Valid/ready channel interfaces for the path slash normalizer.
// Depends on psc_pkg for the field widths.
interface psc_in_if;
    logic                      valid;
    logic                      ready;
    logic [psc_pkg::CODE_W-1:0] code_point;
    logic                      final_char;

    modport source (output valid, output code_point, output final_char, input ready);
    modport sink   (input valid, input code_point, input final_char, output ready);
endinterface

interface psc_out_if;
    logic                      valid;
    logic                      ready;
    logic [psc_pkg::CODE_W-1:0] out_char;
    logic                      has_char;
    logic                      path_end;

    modport source (output valid, output out_char, output has_char, output path_end,
                    input ready);
    modport sink   (input valid, input out_char, input has_char, input path_end,
                    output ready);
endinterface

### rtl/psc_step.sv
// Next-mode and result logic for one character of a path.
// Depends on psc_pkg.
module psc_step (
    input  psc_pkg::t_scan_mode        i_mode,
    input  logic [psc_pkg::CODE_W-1:0] i_char,
    input  logic                       i_last,
    output psc_pkg::t_scan_mode        o_next_mode,
    output psc_pkg::t_step_out         o_step
);
    import psc_pkg::*;

    logic [CODE_W-1:0] c;
    logic              slash;
    t_scan_mode        mid_mode;
    logic [1:0]        n_mid;
    logic [CODE_W-1:0] ch0;
    logic [CODE_W-1:0] ch1;
    logic [1:0]        n_fin;
    logic [CODE_W-1:0] f0;
    logic [CODE_W-1:0] f1;
    logic              h0;
    logic              h1;

    assign c     = i_char & CHAR_MASK;
    assign slash = (c == SLASH_CHAR);

    // Per-mode update before end-of-path handling
    always_comb begin
        mid_mode = i_mode;
        n_mid    = 2'd0;
        ch0      = c;
        ch1      = c;
        case (i_mode)
            MODE_START: begin
                n_mid    = 2'd1;
                mid_mode = slash ? MODE_ROOT1 : MODE_BODY;
            end
            MODE_ROOT1: begin
                if (slash) begin
                    mid_mode = MODE_ROOT2;
                end else begin
                    n_mid    = 2'd1;
                    mid_mode = MODE_BODY;
                end
            end
            MODE_ROOT2: begin
                if (slash) begin
                    mid_mode = MODE_ROOT3;
                end else begin
                    n_mid    = 2'd2;
                    ch0      = SLASH_CHAR;
                    mid_mode = MODE_BODY;
                end
            end
            MODE_ROOT3: begin
                if (!slash) begin
                    n_mid    = 2'd1;
                    mid_mode = MODE_BODY;
                end
            end
            MODE_BODY: begin
                if (slash) begin
                    mid_mode = MODE_RUN;
                end else begin
                    n_mid = 2'd1;
                end
            end
            default: begin
                if (!slash) begin
                    n_mid    = 2'd2;
                    ch0      = SLASH_CHAR;
                    mid_mode = MODE_BODY;
                end else begin
                    mid_mode = MODE_RUN;
                end
            end
        endcase
    end

    // End of path: release a held root slash, or give a bare end mark
    always_comb begin
        n_fin       = n_mid;
        f0          = ch0;
        f1          = ch1;
        h0          = 1'b1;
        h1          = 1'b1;
        o_next_mode = mid_mode;
        if (i_last) begin
            o_next_mode = MODE_START;
            if (mid_mode == MODE_ROOT2) begin
                // held slash is the only result in this case
                n_fin = 2'd1;
                f0    = SLASH_CHAR;
            end else if (n_mid == 2'd0) begin
                n_fin = 2'd1;
                f0    = '0;
                h0    = 1'b0;
            end
        end
    end

    always_comb begin
        o_step.count         = n_fin;
        o_step.res0.out_char = f0;
        o_step.res0.has_char = h0;
        o_step.res0.path_end = i_last && (n_fin == 2'd1);
        o_step.res1.out_char = f1;
        o_step.res1.has_char = h1;
        o_step.res1.path_end = i_last;
    end

endmodule

### rtl/psc_obuf.sv
// Two-entry result buffer: takes all results of one beat at once and
// drains them one per cycle while o_out is ready. Depends on psc_pkg and psc_if.
module psc_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load_req,
    input  psc_pkg::t_step_out   i_step,
    output logic                 o_load,
    psc_out_if.source            o_out
);
    import psc_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_slot0;
    t_result    n_slot0;
    t_result    r_slot1;
    t_result    n_slot1;
    logic       pop;

    assign pop    = o_out.valid && o_out.ready;
    // Room when empty, or when the single held result leaves this cycle
    assign o_load = i_load_req && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));

    // Next buffer contents
    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (o_load) begin
            n_cnt   = i_step.count;
            n_slot0 = i_step.res0;
            n_slot1 = i_step.res1;
        end else if (pop) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_char = r_slot0.out_char;
    assign o_out.has_char = r_slot0.has_char;
    assign o_out.path_end = r_slot0.path_end;

endmodule

### rtl/path_slash_collapse_top.sv
// Path slash normalizer: usage notes
// i_in carries one path character per beat (code_point) with final_char set
// on the last character of the path. o_out carries the normalized path, one
// character per beat, with path_end set on its last beat; a path whose last
// character emits nothing ends with a beat with has_char 0 and out_char 0.
// A leading "//" is kept, three or more leading slashes become "/", later
// slash runs collapse to one and trailing slashes are dropped.
// A character goes through the input register and then the result buffer
// before it can appear on o_out.
// Throughput: one input beat per cycle while o_out does not stall and each beat
// gives at most one result; a beat that releases a held slash gives two results,
// drained through the single result port, and holds back the next input beat.
// Reset (synchronous, i_rst_n low) empties the input and result registers
// and returns the scan to path start. When o_out stalls, the two-entry result
// buffer and input register hold and i_in.ready falls; no beat is lost.
// Depends on psc_pkg, psc_if, psc_step and psc_obuf.
module path_slash_collapse_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psc_in_if.sink     i_in,
    psc_out_if.source  o_out
);
    import psc_pkg::*;

    logic              r_in_valid;
    logic [CODE_W-1:0] r_in_char;
    logic              r_in_last;
    t_scan_mode        r_mode;
    t_scan_mode        step_next_mode;
    t_step_out         step_out;
    logic              load;
    logic              take;

    // Input register frees up whenever its beat moves into the result buffer
    assign i_in.ready = !r_in_valid || load;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_START;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_mode <= step_next_mode;
            end
        end
        if (take) begin
            r_in_char <= i_in.code_point;
            r_in_last <= i_in.final_char;
        end
    end

    psc_step u_step (
        .i_mode      (r_mode),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .o_next_mode (step_next_mode),
        .o_step      (step_out)
    );

    psc_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_req (r_in_valid),
        .i_step     (step_out),
        .o_load     (load),
        .o_out      (o_out)
    );

endmodule
